>>> rtl/core/tristate_rf_switch_encoder_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tri-state switch encoder checker.
// Each macro expects signals named clk and rst in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef TRISTATE_RF_SWITCH_ENCODER_TOP_ASSERT_SVH
`define TRISTATE_RF_SWITCH_ENCODER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TRSW_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TRSW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/trsw_pkg.sv
// ----------------------------------------------------------------------------
// trsw_pkg
// Shared types and constants of the tri-state switch encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package trsw_pkg;

  // Configuration register indexes.
  typedef enum logic {
    CFG_PULSE_LENGTH = 1'b0,
    CFG_REPEAT_COUNT = 1'b1
  } cfg_index_t;

  // Input item operations.
  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } opcode_t;

  localparam logic [15:0] PULSE_LENGTH_RESET = 16'd350;
  localparam logic [7:0]  REPEAT_COUNT_RESET = 8'd10;
  localparam logic [3:0]  SYNC_INDEX         = 4'd12;
  localparam logic [4:0]  SYNC_LOW_UNITS     = 5'd31;
  localparam int          NUM_SYMBOLS        = 12;

  // A set bit in symbols marks symbol F, a clear bit symbol 0.
  typedef struct packed {
    logic [NUM_SYMBOLS-1:0] symbols;
    logic                   valid;
  } codeword_t;

  typedef struct packed {
    logic pin_level;
    logic busy_res;
    logic start_accepted;
    logic last;
  } result_t;

endpackage

>>> rtl/core/trsw_codeword.sv
// ----------------------------------------------------------------------------
// trsw_codeword
// Builds the 12-symbol tri-state codeword from system code, unit and on/off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trsw_codeword (
  input  logic [4:0]        system_code,
  input  logic [2:0]        unit_code,
  input  logic              switch_on,
  output trsw_pkg::codeword_t codeword
);

  logic       unit_ok;
  logic [2:0] unit_pos;

  assign unit_ok  = (unit_code >= 3'd1) && (unit_code <= 3'd5);
  assign unit_pos = unit_code - 3'd1;

  always_comb begin
    codeword = '0;
    if (unit_ok) begin
      // A system bit of one is sent as symbol 0, hence the inversion.
      codeword.symbols[4:0]  = ~system_code;
      codeword.symbols[9:5]  = 5'h1F & ~(5'b00001 << unit_pos);
      codeword.symbols[10]   = ~switch_on;
      codeword.symbols[11]   = switch_on;
      codeword.valid         = 1'b1;
    end
  end

endmodule

>>> rtl/core/trsw_engine.sv
// ----------------------------------------------------------------------------
// trsw_engine
// Transmission state and pulse timing; one accepted item per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trsw_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic                is_start,
  input  trsw_pkg::codeword_t codeword,
  input  logic [15:0]         pulse_length_ticks,
  input  logic [7:0]          repeat_count,
  output trsw_pkg::result_t   result
);

  logic [11:0] symbol_store, symbol_store_next;
  logic        codeword_valid, codeword_valid_next;
  logic [3:0]  symbol_index, symbol_index_next;
  logic [1:0]  segment_index, segment_index_next;
  logic [4:0]  unit_counter, unit_counter_next;
  logic [15:0] tick_counter, tick_counter_next;
  logic [7:0]  frames_left, frames_left_next;
  logic        active, active_next;

  logic        is_sync;
  logic        is_f;
  logic [15:0] symbols_ext;
  logic [4:0]  seg_units;
  logic [15:0] plen;
  logic        tick_done;
  logic        unit_done;
  logic [7:0]  frames_dec;
  logic        take_start;
  logic        take_tick;
  logic        fin;

  assign is_sync     = symbol_index >= trsw_pkg::SYNC_INDEX;
  assign symbols_ext = {4'b0000, symbol_store};
  assign is_f        = symbols_ext[symbol_index];

  always_comb begin
    if (is_sync) begin
      seg_units = (segment_index == 2'd0) ? 5'd1 : trsw_pkg::SYNC_LOW_UNITS;
    end else begin
      case (segment_index)
        2'd0:    seg_units = 5'd1;
        2'd1:    seg_units = 5'd3;
        2'd2:    seg_units = is_f ? 5'd3 : 5'd1;
        2'd3:    seg_units = is_f ? 5'd1 : 5'd3;
        default: seg_units = 5'd1;
      endcase
    end
  end

  assign plen       = (pulse_length_ticks == 16'd0) ? 16'd1 : pulse_length_ticks;
  assign tick_done  = ({1'b0, tick_counter} + 17'd1) >= {1'b0, plen};
  assign unit_done  = ({1'b0, unit_counter} + 6'd1) >= {1'b0, seg_units};
  assign frames_dec = frames_left - 8'd1;
  assign take_start = step && is_start && !active;
  assign take_tick  = step && !is_start && active;

  always_comb begin
    symbol_store_next   = symbol_store;
    codeword_valid_next = codeword_valid;
    symbol_index_next   = symbol_index;
    segment_index_next  = segment_index;
    unit_counter_next   = unit_counter;
    tick_counter_next   = tick_counter;
    frames_left_next    = frames_left;
    active_next         = active;
    fin                 = 1'b0;
    if (take_start) begin
      symbol_store_next   = codeword.symbols;
      codeword_valid_next = codeword.valid;
      symbol_index_next   = codeword.valid ? 4'd0 : trsw_pkg::SYNC_INDEX;
      segment_index_next  = 2'd0;
      unit_counter_next   = 5'd0;
      tick_counter_next   = 16'd0;
      frames_left_next    = (repeat_count == 8'd0) ? 8'd1 : repeat_count;
      active_next         = 1'b1;
    end else if (take_tick) begin
      if (!tick_done) begin
        tick_counter_next = tick_counter + 16'd1;
      end else begin
        tick_counter_next = 16'd0;
        if (!unit_done) begin
          unit_counter_next = unit_counter + 5'd1;
        end else begin
          unit_counter_next = 5'd0;
          if (is_sync) begin
            if (segment_index == 2'd0) begin
              segment_index_next = 2'd1;
            end else begin
              segment_index_next = 2'd0;
              frames_left_next   = frames_dec;
              if (frames_dec == 8'd0) begin
                active_next       = 1'b0;
                symbol_index_next = 4'd0;
                fin               = 1'b1;
              end else begin
                symbol_index_next = codeword_valid ? 4'd0 : trsw_pkg::SYNC_INDEX;
              end
            end
          end else if (segment_index == 2'd3) begin
            segment_index_next = 2'd0;
            symbol_index_next  = symbol_index + 4'd1;
          end else begin
            segment_index_next = segment_index + 2'd1;
          end
        end
      end
    end
  end

  // Start items report the level after the start; ticks report the level
  // before time advances.
  always_comb begin
    result                = '0;
    result.last           = fin;
    result.start_accepted = take_start;
    if (is_start) begin
      result.busy_res  = active_next;
      result.pin_level = take_start || (active && !segment_index[0]);
    end else begin
      result.busy_res  = active;
      result.pin_level = active && !segment_index[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_store   <= '0;
      codeword_valid <= 1'b0;
      symbol_index   <= '0;
      segment_index  <= '0;
      unit_counter   <= '0;
      tick_counter   <= '0;
      frames_left    <= '0;
      active         <= 1'b0;
    end else begin
      symbol_store   <= symbol_store_next;
      codeword_valid <= codeword_valid_next;
      symbol_index   <= symbol_index_next;
      segment_index  <= segment_index_next;
      unit_counter   <= unit_counter_next;
      tick_counter   <= tick_counter_next;
      frames_left    <= frames_left_next;
      active         <= active_next;
    end
  end

endmodule

>>> rtl/core/tristate_rf_switch_encoder_top.sv
// ----------------------------------------------------------------------------
// tristate_rf_switch_encoder_top
// Each result is registered in the output register when its item is taken.
// Throughput: one item per cycle unless the consumer stalls; the state update and
// result logic of the timing engine finish within the accepting cycle.
// Reset: synchronous active-high rst idles the transmitter and loads the
// configuration defaults (350 ticks per pulse unit, 10 frames).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tristate_rf_switch_encoder_top (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port.
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  // Input items.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [4:0]  system_code,
  input  logic [2:0]  unit_code,
  input  logic        switch_on,
  // Result items.
  output logic        out_valid,
  input  logic        out_ready,
  output logic        pin_level,
  output logic        busy_res,
  output logic        start_accepted,
  output logic        last
);

  logic [15:0]          pulse_length_ticks;
  logic [7:0]           repeat_count;
  logic                 in_transfer;
  trsw_pkg::codeword_t  codeword;
  trsw_pkg::result_t    result;

  // A new item is taken whenever the output register is empty or is being
  // drained in the same cycle, so a waiting result blocks the input only
  // while the consumer stalls.
  assign in_ready    = !out_valid || out_ready;
  assign in_transfer = in_valid && in_ready;

  // Configuration registers. A new pulse length takes effect on the next
  // tick, even in the middle of a transmission; the repeat count is only
  // read when a start is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_length_ticks <= trsw_pkg::PULSE_LENGTH_RESET;
      repeat_count       <= trsw_pkg::REPEAT_COUNT_RESET;
    end else if (cfg_write) begin
      case (trsw_pkg::cfg_index_t'(cfg_index))
        trsw_pkg::CFG_PULSE_LENGTH: pulse_length_ticks <= cfg_data;
        trsw_pkg::CFG_REPEAT_COUNT: repeat_count       <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // The codeword is built from the start fields directly; the engine only
  // latches it when a start is actually taken.
  trsw_codeword u_codeword (
    .system_code (system_code),
    .unit_code   (unit_code),
    .switch_on   (switch_on),
    .codeword    (codeword)
  );

  trsw_engine u_engine (
    .clk                (clk),
    .rst                (rst),
    .step               (in_transfer),
    .is_start           (opcode == trsw_pkg::OP_START),
    .codeword           (codeword),
    .pulse_length_ticks (pulse_length_ticks),
    .repeat_count       (repeat_count),
    .result             (result)
  );

  // Output register: the valid flag is control state, the payload simply
  // loads on each input transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_transfer) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_transfer) begin
      pin_level      <= result.pin_level;
      busy_res       <= result.busy_res;
      start_accepted <= result.start_accepted;
      last           <= result.last;
    end
  end

endmodule

>>> rtl/core/trsw_checker.sv
// ----------------------------------------------------------------------------
// trsw_checker
// Port-level checks of the tri-state switch encoder, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "tristate_rf_switch_encoder_top_assert.svh"

module trsw_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input logic pin_level,
  input logic busy_res,
  input logic start_accepted,
  input logic last
);

  logic [3:0] payload;
  logic       stalled;
  logic       start_seen;
  logic       last_seen;
  logic       first_high;
  logic       sync_low;

  assign payload    = {pin_level, busy_res, start_accepted, last};
  assign stalled    = out_valid && !out_ready;
  assign start_seen = out_valid && start_accepted;
  assign last_seen  = out_valid && last;
  assign first_high = busy_res && pin_level && !last;
  assign sync_low   = busy_res && !pin_level && !start_accepted;

  // A stalled result keeps its payload.
  `TRSW_ASSERT_NEXT(a_out_hold, stalled, out_valid && $stable(payload), "stalled result changed")

  // The pin can only be driven during a transmission.
  `TRSW_ASSERT_SAME(a_pin_busy, out_valid && pin_level, busy_res, "pin high while idle")

  // An accepted start begins with the first high pulse.
  `TRSW_ASSERT_SAME(a_start_high, start_seen, first_high, "accepted start not high and busy")

  // The final tick belongs to the low part of the sync.
  `TRSW_ASSERT_SAME(a_last_low, last_seen, sync_low, "last tick not in sync low")

endmodule

bind tristate_rf_switch_encoder_top trsw_checker u_trsw_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .pin_level      (pin_level),
  .busy_res       (busy_res),
  .start_accepted (start_accepted),
  .last           (last)
);

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the tri-state on-off keyed switch encoder. Tick and
// start transfers go in through a valid/ready port with random gaps. Every
// transfer is run through a cycle-free model of the frame timing. The level,
// busy, start and last flags that come back are compared in order against
// that model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  // Generous ceiling. A correct run needs a small fraction of this even with
  // the longest sender gaps, the longest receiver stalls and the long hold.
  localparam int CYCLE_LIMIT  = 600000;
  localparam int NUM_PHASES   = 7;
  // Transfers per random phase that actually move the transmitter.
  localparam int PHASE_ITEMS  = 160;
  // Accepted transfers after which the receiver holds off for a long stretch.
  localparam int HOLD_AFTER   = 300;
  localparam int HOLD_CYCLES  = 400;
  localparam int MAX_REPORTED = 10;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_write;
  logic        cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic        opcode;
  logic [4:0]  system_code;
  logic [2:0]  unit_code;
  logic        switch_on;
  logic        out_valid;
  logic        out_ready;
  logic        pin_level;
  logic        busy_res;
  logic        start_accepted;
  logic        last;

  // Mostly one or zero ticks per pulse unit so that whole transmissions fit
  // in the run. Zero pulse length and zero repeat count get phases of their
  // own, and the large extremes are written in the directed part.
  logic [15:0] phase_pulse  [NUM_PHASES] = '{16'd1, 16'd2, 16'd0, 16'd1, 16'd3, 16'd1, 16'd0};
  logic [7:0]  phase_repeat [NUM_PHASES] = '{8'd1, 8'd2, 8'd1, 8'd3, 8'd0, 8'd2, 8'd1};

  int unsigned cycle_count = 0;
  int          send_calm   = 0;

  // --------------------------------------------------------------------------
  // Scoreboard. It keeps its own copy of the transmitter state and the two
  // registers. Each accepted input transfer is stepped through that state and
  // the result it must produce is queued. Results are checked in order.
  // --------------------------------------------------------------------------
  class ook_frame_checker;
    logic [15:0]         pulse_len;
    logic [7:0]          repeats;
    trsw_pkg::codeword_t cw;
    logic [3:0]          sym_idx;
    logic [1:0]          seg;
    logic [4:0]          unit_cnt;
    logic [15:0]         tick_cnt;
    logic [7:0]          frames;
    logic                active;
    trsw_pkg::result_t   due_results[$];
    int                  accepted;
    int                  effective;
    int                  failures;

    function new();
      pulse_len = trsw_pkg::PULSE_LENGTH_RESET;
      repeats   = trsw_pkg::REPEAT_COUNT_RESET;
      cw        = '0;
      sym_idx   = '0;
      seg       = '0;
      unit_cnt  = '0;
      tick_cnt  = '0;
      frames    = '0;
      active    = 1'b0;
      accepted  = 0;
      effective = 0;
      failures  = 0;
    endfunction

    function void write_config(trsw_pkg::cfg_index_t idx, logic [15:0] data);
      if (idx == trsw_pkg::CFG_PULSE_LENGTH) pulse_len = data;
      else repeats = data[7:0];
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    // The line is high in the even segments (first and second high) and low
    // in the odd ones; the sync uses only segments zero and one.
    function logic line_level();
      return active && !seg[0];
    endfunction

    // Length in pulse units of the segment now being sent.
    function logic [4:0] seg_units();
      logic is_f;
      if (sym_idx >= trsw_pkg::SYNC_INDEX)
        return (seg == 2'd0) ? 5'd1 : trsw_pkg::SYNC_LOW_UNITS;
      is_f = cw.symbols[sym_idx];
      case (seg)
        2'd0: return 5'd1;
        2'd1: return 5'd3;
        2'd2: return is_f ? 5'd3 : 5'd1;
        default: return is_f ? 5'd1 : 5'd3;
      endcase
    endfunction

    // One tick of time. Returns one when the final tick of the final sync
    // has just gone out.
    function logic step_tick();
      logic [16:0] plen_eff;
      plen_eff = (pulse_len == 16'd0) ? 17'd1 : {1'b0, pulse_len};
      // A shortened pulse length ends the unit as soon as the count reaches
      // or passes it.
      if ({1'b0, tick_cnt} + 17'd1 < plen_eff) begin
        tick_cnt = tick_cnt + 16'd1;
        return 1'b0;
      end
      tick_cnt = '0;
      if ({1'b0, unit_cnt} + 6'd1 < {1'b0, seg_units()}) begin
        unit_cnt = unit_cnt + 5'd1;
        return 1'b0;
      end
      unit_cnt = '0;
      if (sym_idx >= trsw_pkg::SYNC_INDEX) begin
        if (seg == 2'd0) begin
          seg = 2'd1;
          return 1'b0;
        end
        seg    = 2'd0;
        frames = frames - 8'd1;
        if (frames == 8'd0) begin
          active  = 1'b0;
          sym_idx = '0;
          return 1'b1;
        end
        sym_idx = cw.valid ? 4'd0 : trsw_pkg::SYNC_INDEX;
        return 1'b0;
      end
      if (seg == 2'd3) begin
        seg     = 2'd0;
        sym_idx = sym_idx + 4'd1;
      end else begin
        seg = seg + 2'd1;
      end
      return 1'b0;
    endfunction

    function void note_transfer(trsw_pkg::opcode_t op, logic [4:0] sys, logic [2:0] unit,
                                logic on);
      trsw_pkg::result_t r;
      r = '0;
      if (op == trsw_pkg::OP_START) begin
        if (!active) begin
          if (unit >= 3'd1 && unit <= 3'd5) begin
            // System bits are inverted (a set bit sends symbol 0), the unit
            // field is one-hot low, and on/off picks 0F or F0.
            cw.symbols[4:0]  = ~sys;
            cw.symbols[9:5]  = 5'h1F & ~(5'd1 << (unit - 3'd1));
            cw.symbols[10]   = ~on;
            cw.symbols[11]   = on;
            cw.valid         = 1'b1;
          end else begin
            cw = '0;
          end
          sym_idx  = cw.valid ? 4'd0 : trsw_pkg::SYNC_INDEX;
          seg      = '0;
          unit_cnt = '0;
          tick_cnt = '0;
          frames   = (repeats != 8'd0) ? repeats : 8'd1;
          active   = 1'b1;
          r.start_accepted = 1'b1;
          effective++;
        end
        r.pin_level = line_level();
        r.busy_res  = active;
      end else if (active) begin
        r.pin_level = line_level();
        r.busy_res  = 1'b1;
        r.last      = step_tick();
        effective++;
      end
      accepted++;
      due_results.push_back(r);
    endfunction

    function void note_failure(string what);
      failures++;
      if (failures <= MAX_REPORTED) $display("MISMATCH %0d: %s", failures, what);
    endfunction

    function void compare_flag(string field, logic want, logic got);
      if (got !== want)
        note_failure($sformatf("%s expected %b got %b (result %0d)", field, want, got,
                               accepted - due_results.size()));
    endfunction

    function void check_transfer(trsw_pkg::result_t got);
      trsw_pkg::result_t want;
      if (due_results.size() == 0) begin
        note_failure($sformatf("unexpected result pin %b busy %b start %b last %b",
                               got.pin_level, got.busy_res, got.start_accepted, got.last));
        return;
      end
      want = due_results.pop_front();
      compare_flag("pin_level", want.pin_level, got.pin_level);
      compare_flag("busy_res", want.busy_res, got.busy_res);
      compare_flag("start_accepted", want.start_accepted, got.start_accepted);
      compare_flag("last", want.last, got.last);
    endfunction
  endclass

  ook_frame_checker chk;

  tristate_rf_switch_encoder_top u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .system_code    (system_code),
    .unit_code      (unit_code),
    .switch_on      (switch_on),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .pin_level      (pin_level),
    .busy_res       (busy_res),
    .start_accepted (start_accepted),
    .last           (last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hard stop in case the block hangs or drops results.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Random pause after an input transfer. Most transfers follow back to back,
  // some wait a few cycles, a few wait long, and now and then a calm stretch
  // sends with no gaps at all.
  task automatic sender_gap();
    int roll;
    int n;
    if (send_calm > 0) begin
      send_calm--;
      return;
    end
    roll = $urandom_range(0, 99);
    n    = 0;
    if (roll < 2) send_calm = $urandom_range(30, 80);
    else if (roll < 5) n = $urandom_range(15, 40);
    else if (roll < 30) n = $urandom_range(1, 3);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Offers one input transfer and holds it until the block takes it. The
  // scoreboard hears of it in the same step, so the next random choice sees
  // the transmitter state after this transfer.
  task automatic send_item(trsw_pkg::opcode_t op, logic [4:0] sys, logic [2:0] unit,
                           logic on);
    in_valid    <= 1'b1;
    opcode      <= op;
    system_code <= sys;
    unit_code   <= unit;
    switch_on   <= on;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    chk.note_transfer(op, sys, unit, on);
    sender_gap();
  endtask

  // Starts come often while the transmitter is idle and rarely while it is
  // busy, where they must be ignored. One start in four picks a unit number
  // outside one to five, which sends the sync alone.
  task automatic send_random_item();
    trsw_pkg::opcode_t op;
    logic [2:0]        unit;
    int                pick;
    op = trsw_pkg::OP_TICK;
    if (!chk.active && $urandom_range(0, 2) == 0) op = trsw_pkg::OP_START;
    else if (chk.active && $urandom_range(0, 39) == 0) op = trsw_pkg::OP_START;
    if ($urandom_range(0, 3) != 0) begin
      unit = 3'($urandom_range(1, 5));
    end else begin
      pick = $urandom_range(0, 2);
      unit = (pick == 0) ? 3'd0 : 3'(5 + pick);
    end
    send_item(op, 5'($urandom_range(0, 31)), unit, 1'($urandom_range(0, 1)));
  endtask

  // Stops offering and waits until every queued result has come back, then
  // idles so that the output register settles.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (chk.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(trsw_pkg::cfg_index_t idx, logic [15:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    chk.write_config(idx, data);
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Result side. Checks every result transfer and drives out_ready with
  // random stalls. Once enough transfers have gone in, the receiver holds off
  // for a long stretch so that the block fills and stalls its input.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int                stall_left;
    int                calm_left;
    int                roll;
    bit                hold_done;
    trsw_pkg::result_t got;
    stall_left = 0;
    calm_left  = 0;
    hold_done  = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        got = '{pin_level, busy_res, start_accepted, last};
        chk.check_transfer(got);
      end
      if (!hold_done && chk.accepted >= HOLD_AFTER) begin
        hold_done  = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (calm_left > 0) begin
        calm_left--;
        out_ready <= 1'b1;
      end else begin
        roll = $urandom_range(0, 199);
        if (roll < 2) calm_left = $urandom_range(40, 120);
        else if (roll < 5) stall_left = $urandom_range(15, 40);
        else if (roll < 50) stall_left = $urandom_range(1, 3);
        if (stall_left > 0) begin
          stall_left--;
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side and run control.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    chk = new();
    rst         <= 1'b1;
    cfg_write   <= 1'b0;
    cfg_index   <= trsw_pkg::CFG_PULSE_LENGTH;
    cfg_data    <= '0;
    in_valid    <= 1'b0;
    opcode      <= trsw_pkg::OP_TICK;
    system_code <= '0;
    unit_code   <= '0;
    switch_on   <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // A tick on an idle transmitter must leave everything low.
    send_item(trsw_pkg::OP_TICK, 5'h00, 3'd0, 1'b0);
    drain_results();

    // Zero pulse length and zero repeat count both fall back to one. The
    // start uses the top unit number, so it sends one sync-only frame, and
    // a second start with all-zero fields lands while busy and is dropped.
    write_reg(trsw_pkg::CFG_PULSE_LENGTH, 16'd0);
    write_reg(trsw_pkg::CFG_REPEAT_COUNT, 16'd0);
    send_item(trsw_pkg::OP_START, 5'h1F, 3'd7, 1'b0);
    send_item(trsw_pkg::OP_START, 5'h00, 3'd0, 1'b1);
    repeat (3) send_item(trsw_pkg::OP_TICK, 5'h00, 3'd0, 1'b0);
    drain_results();

    // The largest pulse length mid-transmission lets the tick count climb;
    // setting it back to zero then ends the unit at once since the count has
    // passed the new length.
    write_reg(trsw_pkg::CFG_PULSE_LENGTH, 16'hFFFF);
    repeat (4) send_item(trsw_pkg::OP_TICK, 5'h0A, 3'd2, 1'b1);
    drain_results();
    write_reg(trsw_pkg::CFG_PULSE_LENGTH, 16'd0);

    // The repeat count is read only at a start, so the largest value written
    // while busy changes nothing; the start that follows is ignored.
    write_reg(trsw_pkg::CFG_REPEAT_COUNT, 16'd255);
    send_item(trsw_pkg::OP_TICK, 5'h00, 3'd0, 1'b0);
    send_item(trsw_pkg::OP_START, 5'h15, 3'd5, 1'b1);
    send_item(trsw_pkg::OP_TICK, 5'h00, 3'd0, 1'b0);

    // Random phases, each with its own register setting written while no
    // result is outstanding. The transmitter may still be mid-frame, which
    // also exercises a pulse length change during a transmission.
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      write_reg(trsw_pkg::CFG_PULSE_LENGTH, phase_pulse[p]);
      write_reg(trsw_pkg::CFG_REPEAT_COUNT, {8'd0, phase_repeat[p]});
      while (chk.effective < (p + 1) * PHASE_ITEMS + 10) send_random_item();
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (chk.failures == 0 && chk.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
